[hw/rtl/mpjq_pkg.sv]
package mpjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ENQ,
        RES_FULL,
        RES_EMPTY,
        RES_DEQ
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_MOVE_INIT,
        S_MOVE,
        S_MOVE_END
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] prio;
    } t_job;

    typedef struct packed {
        logic enq_wr;
        logic scan_init;
        logic scan_issue;
        logic move_init;
        logic move_issue;
        logic deq_done;
        t_res res;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic move_more;
    } t_dp_sts;

endpackage

[hw/rtl/mpjq_ctrl.sv]
module mpjq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_command,
    input  mpjq_pkg::t_dp_sts i_sts,
    output mpjq_pkg::t_dp_cmd o_cmd,
    output logic              busy
);
    import mpjq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_NONE;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (t_command'(i_command) == CMD_ENQ) begin
                        if (i_sts.full) begin
                            o_cmd.res = RES_FULL;
                        end else begin
                            o_cmd.enq_wr = 1'b1;
                            o_cmd.res    = RES_ENQ;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.res = RES_EMPTY;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_MOVE_INIT;
            end
            S_MOVE_INIT: begin
                o_cmd.move_init = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (i_sts.move_more) begin
                    o_cmd.move_issue = 1'b1;
                end else begin
                    n_state = S_MOVE_END;
                end
            end
            S_MOVE_END: begin
                o_cmd.deq_done = 1'b1;
                o_cmd.res      = RES_DEQ;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mpjq_datapath.sv]
module mpjq_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpjq_pkg::t_dp_cmd i_cmd,
    input  logic [15:0]       i_job_id,
    input  logic [15:0]       i_priority_req,
    output mpjq_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [15:0]       o_out_id,
    output logic [15:0]       o_out_priority,
    output logic [4:0]        o_jobs_held
);
    import mpjq_pkg::*;

    t_job             r_mem [QUEUE_DEPTH];
    t_job             r_rd;
    logic             r_rd_vld;
    logic             r_mv_vld;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] r_best_idx;
    t_job             r_best;
    logic [CNT_W-1:0] r_count;
    logic             r_valid;
    t_status          r_status;
    logic [15:0]      r_out_id;
    logic [15:0]      r_out_prio;

    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_job             wr_data;
    logic [CNT_W-1:0] idx_next;

    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign rd_addr  = i_cmd.move_issue ? IDX_W'(r_idx + IDX_W'(1)) : r_idx;
    assign rd_en    = i_cmd.scan_issue | i_cmd.move_issue;
    assign wr_en    = i_cmd.enq_wr | r_mv_vld;
    assign wr_addr  = i_cmd.enq_wr ? r_count[IDX_W-1:0] : r_wr_idx;
    assign wr_data  = i_cmd.enq_wr ? t_job'{id: i_job_id, prio: i_priority_req} : r_rd;

    assign o_sts.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_last = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_sts.move_more = (idx_next < r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_mv_vld <= 1'b0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            r_mv_vld <= i_cmd.move_issue;
            if (i_cmd.enq_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.deq_done) begin
                r_count <= r_count - CNT_W'(1);
            end
            r_valid <= (i_cmd.res != RES_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_idx <= IDX_W'(idx_next);
        end else if (i_cmd.move_init) begin
            r_idx <= r_best_idx;
        end else if (i_cmd.move_issue) begin
            r_idx <= IDX_W'(idx_next);
        end
        if (i_cmd.scan_issue) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.move_issue) begin
            r_wr_idx <= r_idx;
        end
        if (r_rd_vld && ((r_rd_idx == '0) || (r_rd.prio < r_best.prio))) begin
            r_best     <= r_rd;
            r_best_idx <= r_rd_idx;
        end
        case (i_cmd.res)
            RES_ENQ: begin
                r_status   <= ST_OK;
                r_out_id   <= '0;
                r_out_prio <= '0;
            end
            RES_FULL: begin
                r_status   <= ST_FULL;
                r_out_id   <= '0;
                r_out_prio <= '0;
            end
            RES_EMPTY: begin
                r_status   <= ST_EMPTY;
                r_out_id   <= '0;
                r_out_prio <= '0;
            end
            RES_DEQ: begin
                r_status   <= ST_OK;
                r_out_id   <= r_best.id;
                r_out_prio <= r_best.prio;
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_jobs_held    = 5'(r_count);

endmodule

[hw/rtl/min_priority_job_queue.sv]
// Channel  | Handshake            | Fields
// ---------+----------------------+-----------------------------------------------
// command  | start high, busy low | i_command, i_job_id, i_priority_req
// result   | o_valid, one cycle   | o_status, o_out_id, o_out_priority, o_jobs_held
//
// An enqueue, and any command that finds the queue full or empty, gives its result
// one cycle after the beat, and a new beat may be taken in that cycle.
// A dequeue scans all n held jobs for the lowest priority, then moves every job above that
// slot down one, as the one read port of the job memory serves the scan and compaction.
// Reset is synchronous and active low; it empties the queue and drops any result.
// The receiver cannot stall; busy is the only back pressure.
module min_priority_job_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_command,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_priority_req,
    output logic        busy,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_id,
    output logic [15:0] o_out_priority,
    output logic [4:0]  o_jobs_held
);
    import mpjq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mpjq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    mpjq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_job_id       (i_job_id),
        .i_priority_req (i_priority_req),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_jobs_held    (o_jobs_held)
    );

endmodule

[hw/rtl/mpjq_checker.sv]
module mpjq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [15:0] o_out_id,
    input logic [15:0] o_out_priority,
    input logic [4:0]  o_jobs_held
);
    import mpjq_pkg::*;

    a_beat_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted beat neither busy nor answered");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL || o_status == ST_EMPTY))
        |-> (o_out_id == '0 && o_out_priority == '0))
        else $error("failed command carries job data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_jobs_held == 5'(QUEUE_DEPTH)))
        else $error("full reported with free slots");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_jobs_held == '0))
        else $error("empty reported with jobs held");

endmodule

bind min_priority_job_queue mpjq_checker u_mpjq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_out_id       (o_out_id),
    .o_out_priority (o_out_priority),
    .o_jobs_held    (o_jobs_held)
);
